@@ sv/rbdq_pkg.sv @@
// ----------------------------------------------------------------------------
// rbdq_pkg
// Shared sizes, codes and types for the ring buffer deque core.
// ----------------------------------------------------------------------------
package rbdq_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Field widths on the stream ports
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int READ_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = ((VALUE_W + INDEX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((READ_W + COUNT_W + STATUS_W + 7) / 8) * 8;

  // Sum of front pointer and index, wide enough for both operands plus carry
  localparam int SUM_W = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_GET        = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Result bookkeeping carried alongside the RAM read
  typedef struct packed {
    logic             read_hit;
    logic [CNT_W-1:0] count;
    status_t          status;
  } result_t;

endpackage

@@ sv/rbdq_ram.sv @@
// ----------------------------------------------------------------------------
// rbdq_ram
// Simple dual-port RAM: one write port, one read port with registered output.
// ----------------------------------------------------------------------------
module rbdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; the read word holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/ring_buffer_deque_core.sv @@
// ----------------------------------------------------------------------------
// ring_buffer_deque_core
// Double-ended queue in a circular RAM with front/back pointers and a count.
// ----------------------------------------------------------------------------
// The RAM read and the result info are captured at the edge that takes an action
// word; the result word is then loaded into the output register once it is free.
// Throughput: one action per cycle while results drain; with the result side
// stalled, one more action fills the pending stage and s_tready drops.
// Reset clears pointers, count and the valid flags; RAM contents are left
// as they are and are only read after being written.
// ----------------------------------------------------------------------------
module ring_buffer_deque_core (
  input  logic                                clk,
  input  logic                                rst,
  // Action words
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rbdq_pkg::IN_DATA_W-1:0]      s_tdata,   // [31:0] value, [35:32] index
  input  logic [rbdq_pkg::ACTION_W-1:0]       s_tuser,   // [2:0] action
  // Result words
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rbdq_pkg::OUT_DATA_W-1:0]     m_tdata    // [31:0] read_data,
                                                         // [36:32] count, [38:37] status
);

  // Pointer and count state
  logic [rbdq_pkg::PTR_W-1:0] front_ptr;
  logic [rbdq_pkg::PTR_W-1:0] back_ptr;
  logic [rbdq_pkg::CNT_W-1:0] fill_count;
  logic [rbdq_pkg::PTR_W-1:0] front_ptr_next;
  logic [rbdq_pkg::PTR_W-1:0] back_ptr_next;
  logic [rbdq_pkg::CNT_W-1:0] fill_count_next;

  // Pipeline registers
  logic                pend_valid;
  rbdq_pkg::result_t   pend;
  rbdq_pkg::result_t   pend_next;
  logic                out_free;
  logic                accept;
  logic [rbdq_pkg::OUT_DATA_W-1:0] m_tdata_next;

  // RAM ports
  logic                              ram_wr_en;
  logic [rbdq_pkg::PTR_W-1:0]        ram_wr_addr;
  logic [rbdq_pkg::DATA_WIDTH-1:0]   ram_wr_data;
  logic                              ram_rd_en;
  logic [rbdq_pkg::PTR_W-1:0]        ram_rd_addr;
  logic [rbdq_pkg::DATA_WIDTH-1:0]   ram_rd_data;

  // Unpacked input fields
  rbdq_pkg::action_t                 action;
  logic [rbdq_pkg::VALUE_W-1:0]      value;
  logic [rbdq_pkg::INDEX_W-1:0]      index;

  // Neighbor slots and get address
  logic [rbdq_pkg::PTR_W-1:0]        front_inc;
  logic [rbdq_pkg::PTR_W-1:0]        front_dec;
  logic [rbdq_pkg::PTR_W-1:0]        back_inc;
  logic [rbdq_pkg::PTR_W-1:0]        back_dec;
  logic [rbdq_pkg::SUM_W-1:0]        get_sum;
  logic                              is_full;
  logic                              is_empty;
  logic                              in_range;

  assign action = rbdq_pkg::action_t'(s_tuser);
  assign value  = s_tdata[rbdq_pkg::VALUE_W-1:0];
  assign index  = s_tdata[rbdq_pkg::VALUE_W +: rbdq_pkg::INDEX_W];

  // Output register is free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !pend_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  // Wrap pointers modulo DEPTH
  assign front_inc = (front_ptr == rbdq_pkg::PTR_W'(rbdq_pkg::DEPTH - 1))
                   ? '0 : front_ptr + 1'b1;
  assign front_dec = (front_ptr == '0)
                   ? rbdq_pkg::PTR_W'(rbdq_pkg::DEPTH - 1) : front_ptr - 1'b1;
  assign back_inc  = (back_ptr == rbdq_pkg::PTR_W'(rbdq_pkg::DEPTH - 1))
                   ? '0 : back_ptr + 1'b1;
  assign back_dec  = (back_ptr == '0)
                   ? rbdq_pkg::PTR_W'(rbdq_pkg::DEPTH - 1) : back_ptr - 1'b1;

  assign is_full  = (fill_count >= rbdq_pkg::CNT_W'(rbdq_pkg::DEPTH));
  assign is_empty = (fill_count == '0);
  assign in_range = (rbdq_pkg::SUM_W'(index) < rbdq_pkg::SUM_W'(fill_count));

  // Get address: front plus index, folded once (index is below count when used)
  always_comb begin
    get_sum = rbdq_pkg::SUM_W'(front_ptr) + rbdq_pkg::SUM_W'(index);
    if (get_sum >= rbdq_pkg::SUM_W'(rbdq_pkg::DEPTH)) begin
      get_sum = get_sum - rbdq_pkg::SUM_W'(rbdq_pkg::DEPTH);
    end
  end

  // Decode the action: status, pointer updates and RAM access
  always_comb begin
    front_ptr_next     = front_ptr;
    back_ptr_next      = back_ptr;
    fill_count_next    = fill_count;
    pend_next.read_hit = 1'b0;
    pend_next.status   = rbdq_pkg::ST_OK;
    ram_wr_en          = 1'b0;
    ram_wr_addr        = back_ptr;
    ram_rd_en          = 1'b0;
    ram_rd_addr        = get_sum[rbdq_pkg::PTR_W-1:0];
    case (action)
      rbdq_pkg::ACT_PUSH_BACK: begin
        if (is_full) begin
          pend_next.status = rbdq_pkg::ST_FULL;
        end else begin
          ram_wr_en       = 1'b1;
          ram_wr_addr     = back_ptr;
          back_ptr_next   = back_inc;
          fill_count_next = fill_count + 1'b1;
        end
      end
      rbdq_pkg::ACT_PUSH_FRONT: begin
        if (is_full) begin
          pend_next.status = rbdq_pkg::ST_FULL;
        end else begin
          ram_wr_en       = 1'b1;
          ram_wr_addr     = front_dec;
          front_ptr_next  = front_dec;
          fill_count_next = fill_count + 1'b1;
        end
      end
      rbdq_pkg::ACT_POP_BACK: begin
        if (is_empty) begin
          pend_next.status = rbdq_pkg::ST_EMPTY;
        end else begin
          back_ptr_next   = back_dec;
          fill_count_next = fill_count - 1'b1;
        end
      end
      rbdq_pkg::ACT_POP_FRONT: begin
        if (is_empty) begin
          pend_next.status = rbdq_pkg::ST_EMPTY;
        end else begin
          front_ptr_next  = front_inc;
          fill_count_next = fill_count - 1'b1;
        end
      end
      rbdq_pkg::ACT_GET: begin
        if (!in_range) begin
          pend_next.status = rbdq_pkg::ST_RANGE;
        end else begin
          ram_rd_en          = 1'b1;
          pend_next.read_hit = 1'b1;
        end
      end
      rbdq_pkg::ACT_CLEAR: begin
        front_ptr_next  = '0;
        back_ptr_next   = '0;
        fill_count_next = '0;
      end
      default: begin
      end
    endcase
    pend_next.count = fill_count_next;
    // Gate RAM accesses with the handshake
    ram_wr_en = ram_wr_en && accept;
    ram_rd_en = ram_rd_en && accept;
  end

  assign ram_wr_data = rbdq_pkg::DATA_WIDTH'(value);

  rbdq_ram #(
    .WIDTH (rbdq_pkg::DATA_WIDTH),
    .DEPTH (rbdq_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Advance state on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr  <= '0;
      back_ptr   <= '0;
      fill_count <= '0;
    end else if (accept) begin
      front_ptr  <= front_ptr_next;
      back_ptr   <= back_ptr_next;
      fill_count <= fill_count_next;
    end
  end

  // Hold the result info while the RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (out_free) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_next;
    end
  end

  // Pack the result word: RAM data for a successful get, else zero
  always_comb begin
    m_tdata_next = '0;
    m_tdata_next[rbdq_pkg::READ_W-1:0] = pend.read_hit
                                       ? rbdq_pkg::READ_W'(ram_rd_data)
                                       : '0;
    m_tdata_next[rbdq_pkg::READ_W +: rbdq_pkg::COUNT_W] = rbdq_pkg::COUNT_W'(pend.count);
    m_tdata_next[rbdq_pkg::READ_W + rbdq_pkg::COUNT_W +: rbdq_pkg::STATUS_W] = pend.status;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend_valid) begin
      m_tdata <= m_tdata_next;
    end
  end

endmodule
